>>> rtl/arf_pkg.sv
// arf_pkg: shared types and constants for the average reduced frequency block
// no dependencies
`timescale 1ns / 1ps

package arf_pkg;

    localparam int ID_W   = 16;
    localparam int IN_W   = 32;
    localparam int SUM_W  = 48;

    typedef enum logic
    {
        FUNC_HIT      = 1'b0,
        FUNC_FINALIZE = 1'b1
    } func_t;

    typedef struct packed
    {
        logic [0:0]      func;
        logic [ID_W-1:0] token_id;
        logic [IN_W-1:0] position;
        logic [IN_W-1:0] token_freq;
    } arf_in_t;

    typedef struct packed
    {
        logic [ID_W-1:0]  result_id;
        logic [SUM_W-1:0] arf_value;
        logic             occurred;
    } arf_out_t;

    // one queued word between front and back
    typedef struct packed
    {
        logic             fin;
        logic             in_range;
        logic [ID_W-1:0]  id;
        logic [IN_W-1:0]  pos;
        logic [IN_W-1:0]  freq;
    } arf_cmd_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_READ,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } bk_state_t;

endpackage

>>> rtl/arf_ram.sv
// arf_ram: generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`timescale 1ns / 1ps

module arf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/arf_front.sv
// arf_front: accepts items, masks position, checks id range, two word queue
// depends on arf_pkg
`timescale 1ns / 1ps

module arf_front
    import arf_pkg::*;
#(
    parameter int ID_COUNT = 65536,
    parameter int POS_BITS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  arf_in_t  cmd,
    output logic     busy,
    output logic     q_valid,
    output arf_cmd_t q_word,
    input  logic     q_pop
);

    arf_cmd_t  slot_reg [2];
    logic      rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    arf_cmd_t  w;
    logic      push;

    always_comb
    begin
        w.fin      = (cmd.func == FUNC_FINALIZE);
        w.in_range = ({16'd0, cmd.token_id} < 32'(ID_COUNT));
        w.id       = cmd.token_id;
        w.pos      = cmd.position & IN_W'((64'd1 << POS_BITS) - 64'd1);
        w.freq     = cmd.token_freq;
    end

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = slot_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg ^ q_pop;
        wr_next  = wr_reg ^ push;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/arf_div.sv
// arf_div: restoring divider, one quotient bit per cycle
// depends on arf_pkg
`timescale 1ns / 1ps

module arf_div
    import arf_pkg::*;
#(
    parameter int NUM_W = 88,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CW-1:0]    n_reg, n_next;
    logic             run_reg, run_next, done_reg, done_next;
    logic [DEN_W:0]   sh;

    assign quo  = q_reg;
    assign done = done_reg;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        n_next    = n_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        sh        = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (go)
        begin
            q_next   = num;
            r_next   = '0;
            d_next   = den;
            n_next   = CW'(NUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            q_next = {q_reg[NUM_W-2:0], 1'b0};
            if (sh >= {1'b0, d_reg})
            begin
                r_next    = sh - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = sh;
            end
            n_next = n_reg - CW'(1);
            if (n_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        n_reg <= n_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

endmodule

>>> rtl/arf_back.sv
// arf_back: table read-modify-write, window term and result output
// depends on arf_pkg, arf_ram, arf_div
`timescale 1ns / 1ps

module arf_back
    import arf_pkg::*;
#(
    parameter int ID_COUNT  = 65536,
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [IN_W-1:0] corpus_size,
    input  logic            q_valid,
    input  arf_cmd_t        q_word,
    output logic            q_pop,
    output logic            clearing,
    output logic            done,
    output arf_out_t        result
);

    localparam int AW    = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int ENT_W = 1 + 2 * IN_W + SUM_W;
    localparam int PROD_W = 2 * IN_W + 1;
    localparam int NUM_W = PROD_W + FRAC_BITS;
    localparam logic [SUM_W-1:0] ONE_FX = SUM_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [1:0] KIND_DIV  = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_ONE  = 2'd2;

    bk_state_t state_reg, state_next;
    arf_cmd_t  cur_reg;
    logic [AW:0] clr_reg, clr_next;
    logic        clr_on;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0]    ram_raddr;

    logic             e_seen;
    logic [IN_W-1:0]  e_first, e_prev;
    logic [SUM_W-1:0] e_sum;

    logic [IN_W:0]    gap_reg, gap_next;
    logic [PROD_W-1:0] prod_reg, prod;
    logic [1:0]       kind_reg, kind_next;
    logic             div_go, div_done;
    logic [NUM_W-1:0] div_quo;
    logic [SUM_W-1:0] term;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    arf_out_t         res_reg, res_next;
    logic             done_reg, done_next;
    logic [IN_W:0]    top;

    assign clr_on   = !clr_reg[AW];
    assign clearing = clr_on;
    // hold the entry of the current word once it has been popped
    assign ram_raddr = (state_reg == BK_IDLE) ? AW'(q_word.id) : AW'(cur_reg.id);
    assign {e_seen, e_first, e_prev, e_sum} = ram_rdata;
    assign prod = PROD_W'(gap_reg) * PROD_W'(cur_reg.freq);

    arf_ram #(.WIDTH(ENT_W), .DEPTH(ID_COUNT)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    arf_div #(.NUM_W(NUM_W), .DEN_W(IN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   ({prod, FRAC_BITS'(0)}),
        .den   (corpus_size),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (!clr_on && q_valid)
                begin
                    state_next = BK_READ;
                end
            BK_READ:
                if (!cur_reg.in_range || !e_seen)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    state_next = BK_MUL;
                end
            BK_MUL:
                state_next = (kind_reg == KIND_DIV) ? BK_DIV : BK_DONE;
            BK_DIV:
                if (div_done)
                begin
                    state_next = BK_DONE;
                end
            BK_DONE:
                state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop  = (state_reg == BK_IDLE) && !clr_on && q_valid;
        div_go = (state_reg == BK_MUL) && (kind_reg == KIND_DIV);
        top    = {1'b0, e_first} + {1'b0, corpus_size};
        gap_next  = gap_reg;
        kind_next = kind_reg;
        if (state_reg == BK_READ)
        begin
            if (cur_reg.fin)
            begin
                gap_next = (top >= {1'b0, e_prev}) ? top - {1'b0, e_prev} : '0;
            end
            else
            begin
                gap_next = (cur_reg.pos >= e_prev) ?
                    {1'b0, cur_reg.pos - e_prev} : '0;
            end
            if (corpus_size == '0)
            begin
                kind_next = KIND_ONE;
            end
            else if (cur_reg.freq == '0)
            begin
                kind_next = KIND_ZERO;
            end
            else
            begin
                kind_next = KIND_DIV;
            end
        end
        case (kind_reg)
            KIND_ZERO: term = '0;
            KIND_ONE:  term = ONE_FX;
            default:   term = (prod_reg >= PROD_W'(corpus_size)) ? ONE_FX
                                                                 : SUM_W'(div_quo);
        endcase
        sum_wide = {1'b0, e_sum} + {1'b0, term};
        sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    // table writes, clearing pass and result
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(cur_reg.id);
        ram_wdata = {1'b1, e_first, cur_reg.pos, sum_sat};
        clr_next  = clr_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        if (clr_on)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg[AW-1:0];
            ram_wdata = '0;
            clr_next  = (clr_reg == (AW+1)'(ID_COUNT - 1)) ? {1'b1, AW'(0)}
                                                           : clr_reg + (AW+1)'(1);
        end
        else if (state_reg == BK_READ)
        begin
            if (cur_reg.fin && (!cur_reg.in_range || !e_seen))
            begin
                res_next  = '{result_id: cur_reg.id, arf_value: '0, occurred: 1'b0};
                done_next = 1'b1;
            end
            else if (!cur_reg.fin && cur_reg.in_range && !e_seen)
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, cur_reg.pos, cur_reg.pos, SUM_W'(0)};
            end
        end
        else if (state_reg == BK_DONE)
        begin
            if (cur_reg.fin)
            begin
                res_next  = '{result_id: cur_reg.id, arf_value: sum_sat, occurred: 1'b1};
                done_next = 1'b1;
            end
            else
            begin
                ram_we = 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_word;
        end
        gap_reg  <= gap_next;
        kind_reg <= kind_next;
        if (state_reg == BK_READ)
        begin
            prod_reg <= '0;
        end
        else if (state_reg == BK_MUL)
        begin
            prod_reg <= prod;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

endmodule

>>> rtl/average_reduced_frequency.sv
// average_reduced_frequency: top level, config register, front queue and back engine
// depends on arf_pkg, arf_front, arf_back
//
// channel   dir  handshake            payload
// item      in   start && !busy       cmd (arf_in_t)
// result    out  done, one cycle      result (arf_out_t)
// config    in   cfg_we               cfg_data (corpus_size)
//
// in the back engine an item of a new or out of range id passes only through
// the read state, a seen id with zero corpus size or zero frequency through the
// read, multiply and done states, and any other item also through the divide
// state, where the bit-serial divider runs; done is registered. after reset a
// clearing pass writes every table entry before the first item is taken. busy is
// high while clearing or the two word queue is full; results cannot be stalled.
`timescale 1ns / 1ps

module average_reduced_frequency
    import arf_pkg::*;
#(
    parameter int ID_COUNT  = 65536,
    parameter int POS_BITS  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  arf_in_t         cmd,
    output logic            busy,
    input  logic            cfg_we,
    input  logic [IN_W-1:0] cfg_data,
    output logic            done,
    output arf_out_t        result
);

    logic [IN_W-1:0] size_reg;
    logic            q_valid, q_pop, clearing, fbusy;
    arf_cmd_t        q_word;

    assign busy = fbusy || clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= IN_W'(1);
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_data;
        end
    end

    arf_front #(.ID_COUNT(ID_COUNT), .POS_BITS(POS_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start && !clearing),
        .cmd     (cmd),
        .busy    (fbusy),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop)
    );

    arf_back #(.ID_COUNT(ID_COUNT), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .corpus_size (size_reg),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .done        (done),
        .result      (result)
    );

`ifndef NO_ASSERTIONS
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop) else $error("pop during clear");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_no_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !done) else $error("result during clear");
`endif

endmodule
